>>> design/mcm_pkg.sv
// Package for the MIDI clock metronome: item kinds, MIDI event codes,
// configuration register indexes, field widths and shared types.
// No dependencies.
`timescale 1ns / 1ps

package mcm_pkg;

    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int SAMPLE_W    = 16;
    localparam int EVENT_W     = 3;
    localparam int SPT_W       = 31;
    localparam int LEN_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam int CLICK_DEPTH_DEFAULT       = 256;
    localparam int TICKS_PER_QUARTER_DEFAULT = 24;

    localparam logic [SPT_W-1:0] ONE_SAMPLE_Q16 = SPT_W'(65536);
    localparam logic [SPT_W-1:0] SPT_RESET      = SPT_W'(1572864000);

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 3'd0,
        KIND_START    = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_CONTINUE = 3'd3,
        KIND_LOAD     = 3'd4
    } mcm_kind_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_START    = 3'd1,
        EV_STOP     = 3'd2,
        EV_CONTINUE = 3'd3,
        EV_CLOCK    = 3'd4
    } mcm_event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLES_PER_TICK = 2'd0,
        REG_CLICK_ENABLE     = 2'd1,
        REG_CLICK_LENGTH     = 2'd2
    } mcm_reg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] midi_event;
        logic               quarter_pulse;
        logic               click_active;
    } mcm_flags_t;

endpackage

>>> design/mcm_item_if.sv
// Input beat channel: transport, sample and click load items.
// Depends on mcm_pkg.
`timescale 1ns / 1ps

interface mcm_item_if
    import mcm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [INDEX_W-1:0]         click_index;
    logic signed [SAMPLE_W-1:0] click_value;

    modport source (output valid, kind, click_index, click_value, input ready);
    modport sink   (input valid, kind, click_index, click_value, output ready);
endinterface

>>> design/mcm_result_if.sv
// Result beat channel: MIDI event, quarter pulse and click sample.
// Depends on mcm_pkg.
`timescale 1ns / 1ps

interface mcm_result_if
    import mcm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [EVENT_W-1:0]         midi_event;
    logic                       quarter_pulse;
    logic signed [SAMPLE_W-1:0] click_sample;
    logic                       click_active;

    modport source (output valid, midi_event, quarter_pulse, click_sample, click_active,
                    input ready);
    modport sink   (input valid, midi_event, quarter_pulse, click_sample, click_active,
                    output ready);
endinterface

>>> design/mcm_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on mcm_pkg.
`timescale 1ns / 1ps

interface mcm_cfg_if
    import mcm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mcm_click_ram.sv
// Click sample table: one write port, one enabled read port with registered data.
// Depends on mcm_pkg.
`timescale 1ns / 1ps

module mcm_click_ram
    import mcm_pkg::*;
#(
    parameter int CLICK_DEPTH = CLICK_DEPTH_DEFAULT,
    localparam int ADDR_W     = $clog2(CLICK_DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [CLICK_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/midi_clock_metronome.sv
// MIDI clock generator (24 ppqn by default) with metronome click playback.
// Takes one beat per clock unless the result side stalls: audio sample, start,
// stop, continue or click table write; every beat returns exactly one result
// beat via the stage 1 and output registers. The click table read is the one
// registered stage before the output register; a Q15.16 phase add and compare
// sit in the same stage. Configuration writes are taken every cycle.
// Depends on mcm_pkg, mcm_item_if, mcm_result_if, mcm_cfg_if, mcm_click_ram.
`timescale 1ns / 1ps

module midi_clock_metronome
    import mcm_pkg::*;
#(
    parameter int CLICK_DEPTH       = CLICK_DEPTH_DEFAULT,
    parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    mcm_item_if.sink     item,
    mcm_result_if.source result,
    mcm_cfg_if.sink      cfg
);

    localparam int ADDR_W = $clog2(CLICK_DEPTH);
    localparam int TC_W   = $clog2(TICKS_PER_QUARTER + 1);

    // configuration
    logic [SPT_W-1:0] spt_reg;
    logic             click_enable_reg;
    logic [LEN_W-1:0] click_length_reg;
    logic             cfg_fire;
    logic             cfg_cancel;

    // timing and click state
    logic [SPT_W-1:0] phase_reg, phase_next;
    logic [TC_W-1:0]  tick_count_reg, tick_count_next;
    logic             playing_reg, playing_next;
    logic [LEN_W-1:0] click_pos_reg, click_pos_next;
    logic             click_running_reg, click_running_next;

    // pipeline
    logic       item_fire;
    logic       s1_valid_reg;
    mcm_flags_t s1_flags_reg;
    mcm_flags_t flags_next;
    logic       s1_move;
    logic       out_valid_reg;
    mcm_flags_t out_flags_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;

    // datapath
    logic [SPT_W-1:0]  period;
    logic [SPT_W:0]    ph_sum;
    logic [SPT_W:0]    ph_wrap;
    logic              tick;
    logic [TC_W-1:0]   tc_inc;
    logic [LEN_W-1:0]  eff_len;
    logic              rd_en;
    logic [LEN_W-1:0]  rd_pos;
    logic              wr_en;
    logic [SAMPLE_W-1:0] rd_data;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_cancel = cfg_fire
                        && ((cfg.index == REG_CLICK_LENGTH)
                            || ((cfg.index == REG_CLICK_ENABLE) && !cfg.data[0]));

    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_move;
    assign item_fire  = item.valid && item.ready;

    assign eff_len = ({23'd0, click_length_reg} > 32'(CLICK_DEPTH))
                     ? LEN_W'(CLICK_DEPTH) : click_length_reg;
    assign period  = (spt_reg < ONE_SAMPLE_Q16) ? ONE_SAMPLE_Q16 : spt_reg;
    assign ph_sum  = {1'b0, phase_reg} + {1'b0, ONE_SAMPLE_Q16};
    assign tick    = (ph_sum >= {1'b0, period});
    assign ph_wrap = ph_sum - {1'b0, period};
    assign tc_inc  = tick_count_reg + TC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg          <= SPT_RESET;
            click_enable_reg <= 1'b0;
            click_length_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                REG_SAMPLES_PER_TICK: spt_reg          <= cfg.data[SPT_W-1:0];
                REG_CLICK_ENABLE:     click_enable_reg <= cfg.data[0];
                REG_CLICK_LENGTH:     click_length_reg <= cfg.data[LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        tick_count_next    = tick_count_reg;
        playing_next       = playing_reg;
        click_pos_next     = click_pos_reg;
        click_running_next = click_running_reg;
        flags_next         = '{midi_event: EV_NONE, quarter_pulse: 1'b0, click_active: 1'b0};
        rd_en              = 1'b0;
        rd_pos             = click_pos_reg;
        wr_en              = 1'b0;
        case (item.kind)
            KIND_SAMPLE:
            begin
                if (playing_reg)
                begin
                    if (tick)
                    begin
                        phase_next            = ph_wrap[SPT_W-1:0];
                        flags_next.midi_event = EV_CLOCK;
                        if (tc_inc >= TC_W'(TICKS_PER_QUARTER))
                        begin
                            tick_count_next          = '0;
                            flags_next.quarter_pulse = 1'b1;
                            if (click_enable_reg && (eff_len != '0))
                            begin
                                click_running_next = 1'b1;
                                click_pos_next     = '0;
                            end
                        end
                        else
                        begin
                            tick_count_next = tc_inc;
                        end
                    end
                    else
                    begin
                        phase_next = ph_sum[SPT_W-1:0];
                    end
                end
                if (click_running_next)
                begin
                    rd_pos = click_pos_next;
                    if (click_pos_next < eff_len)
                    begin
                        rd_en                   = 1'b1;
                        flags_next.click_active = 1'b1;
                        click_pos_next          = click_pos_next + LEN_W'(1);
                    end
                    if (click_pos_next >= eff_len)
                    begin
                        click_running_next = 1'b0;
                        click_pos_next     = '0;
                    end
                end
            end
            KIND_START:
            begin
                playing_next          = 1'b1;
                phase_next            = '0;
                tick_count_next       = '0;
                flags_next.midi_event = EV_START;
            end
            KIND_STOP:
            begin
                playing_next          = 1'b0;
                click_running_next    = 1'b0;
                click_pos_next        = '0;
                flags_next.midi_event = EV_STOP;
            end
            KIND_CONTINUE:
            begin
                playing_next          = 1'b1;
                flags_next.midi_event = EV_CONTINUE;
            end
            KIND_LOAD:
            begin
                wr_en = (32'(item.click_index) < CLICK_DEPTH);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= '0;
            tick_count_reg    <= '0;
            playing_reg       <= 1'b0;
            click_pos_reg     <= '0;
            click_running_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                phase_reg      <= phase_next;
                tick_count_reg <= tick_count_next;
                playing_reg    <= playing_next;
                click_pos_reg  <= click_pos_next;
            end
            if (cfg_cancel)
            begin
                click_running_reg <= 1'b0;
            end
            else if (item_fire)
            begin
                click_running_reg <= click_running_next;
            end
        end
    end

    mcm_click_ram #(
        .CLICK_DEPTH (CLICK_DEPTH)
    ) u_click_ram (
        .clk     (clk),
        .wr_en   (item_fire && wr_en),
        .wr_addr (ADDR_W'(item.click_index)),
        .wr_data (item.click_value),
        .rd_en   (item_fire && rd_en),
        .rd_addr (ADDR_W'(rd_pos)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_flags_reg <= flags_next;
        end
        if (s1_move)
        begin
            out_flags_reg  <= s1_flags_reg;
            out_sample_reg <= s1_flags_reg.click_active ? rd_data : '0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.midi_event    = out_flags_reg.midi_event;
    assign result.quarter_pulse = out_flags_reg.quarter_pulse;
    assign result.click_sample  = out_sample_reg;
    assign result.click_active  = out_flags_reg.click_active;

    a_pulse_on_clock: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.quarter_pulse |-> s1_flags_reg.midi_event == EV_CLOCK)
        else $error("quarter pulse without a clock tick");

    a_click_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        click_running_reg |-> click_pos_reg < eff_len)
        else $error("running click position past its length");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg < TC_W'(TICKS_PER_QUARTER))
        else $error("tick counter out of range");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.kind == KIND_STOP |=> !playing_reg && !click_running_reg)
        else $error("stop left transport or click running");

endmodule

>>> tb/mcm_checker.sv
// Checker for the MIDI clock metronome: watches the item, result and config
// channels, predicts each result beat and compares it field by field.
// Depends on mcm_pkg, mcm_item_if, mcm_result_if, mcm_cfg_if.
`timescale 1ns / 1ps

module mcm_checker
    import mcm_pkg::*;
#(
    parameter int CLICK_DEPTH       = CLICK_DEPTH_DEFAULT,
    parameter int TICKS_PER_QUARTER = TICKS_PER_QUARTER_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    mcm_item_if   item_bus,
    mcm_result_if res_bus,
    mcm_cfg_if    cfg_bus,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic [EVENT_W-1:0]  midi_event;
        logic                quarter_pulse;
        logic [SAMPLE_W-1:0] click_sample;
        logic                click_active;
    } midi_beat_t;

    midi_beat_t midi_beats_due[$];

    logic [SPT_W-1:0]    tick_period;
    logic                click_on;
    logic [LEN_W-1:0]    click_len;
    logic [SPT_W-1:0]    phase_acc;
    int                  tick_cnt;
    logic                playing;
    int                  click_pos;
    logic                click_run;
    logic [SAMPLE_W-1:0] click_tbl [CLICK_DEPTH];

    function automatic midi_beat_t next_midi_beat(input logic [KIND_W-1:0] kind,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [SAMPLE_W-1:0] val);
        midi_beat_t       beat;
        logic [SPT_W:0]   ph;
        logic [SPT_W-1:0] period;
        int               eff_len;
        beat = '0;
        eff_len = (int'(click_len) > CLICK_DEPTH) ? CLICK_DEPTH : int'(click_len);
        case (kind)
            KIND_SAMPLE:
            begin
                if (playing)
                begin
                    period = (tick_period < ONE_SAMPLE_Q16) ? ONE_SAMPLE_Q16 : tick_period;
                    ph = {1'b0, phase_acc} + {1'b0, ONE_SAMPLE_Q16};
                    if (ph >= {1'b0, period})
                    begin
                        ph = ph - {1'b0, period};
                        beat.midi_event = EV_CLOCK;
                        tick_cnt++;
                        if (tick_cnt >= TICKS_PER_QUARTER)
                        begin
                            tick_cnt = 0;
                            beat.quarter_pulse = 1'b1;
                            if (click_on && eff_len > 0)
                            begin
                                click_run = 1'b1;
                                click_pos = 0;
                            end
                        end
                    end
                    phase_acc = ph[SPT_W-1:0];
                end
                if (click_run)
                begin
                    if (click_pos < eff_len && click_pos < CLICK_DEPTH)
                    begin
                        beat.click_sample = click_tbl[click_pos];
                        beat.click_active = 1'b1;
                        click_pos++;
                    end
                    if (click_pos >= eff_len)
                    begin
                        click_run = 1'b0;
                        click_pos = 0;
                    end
                end
            end
            KIND_START:
            begin
                playing = 1'b1;
                phase_acc = '0;
                tick_cnt = 0;
                beat.midi_event = EV_START;
            end
            KIND_STOP:
            begin
                playing = 1'b0;
                click_run = 1'b0;
                click_pos = 0;
                beat.midi_event = EV_STOP;
            end
            KIND_CONTINUE:
            begin
                playing = 1'b1;
                beat.midi_event = EV_CONTINUE;
            end
            KIND_LOAD:
            begin
                if (int'(idx) < CLICK_DEPTH)
                    click_tbl[idx] = val;
            end
            default: ;
        endcase
        return beat;
    endfunction

    task automatic cmp_field(input string name, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        midi_beat_t want;
        if (!rst_n)
        begin
            tick_period = SPT_RESET;
            click_on    = 1'b0;
            click_len   = '0;
            phase_acc   = '0;
            tick_cnt    = 0;
            playing     = 1'b0;
            click_pos   = 0;
            click_run   = 1'b0;
            midi_beats_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_SAMPLES_PER_TICK: tick_period = cfg_bus.data[SPT_W-1:0];
                    REG_CLICK_ENABLE:
                    begin
                        click_on = cfg_bus.data[0];
                        if (!click_on)
                            click_run = 1'b0;
                    end
                    REG_CLICK_LENGTH:
                    begin
                        click_len = cfg_bus.data[LEN_W-1:0];
                        click_run = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (res_bus.valid && res_bus.ready)
            begin
                if (midi_beats_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual ev=%0d qp=%0b s=%0h a=%0b",
                             $time, res_bus.midi_event, res_bus.quarter_pulse,
                             res_bus.click_sample, res_bus.click_active);
                    fail_count++;
                end
                else
                begin
                    want = midi_beats_due.pop_front();
                    cmp_field("midi_event", SAMPLE_W'(want.midi_event),
                              SAMPLE_W'(res_bus.midi_event));
                    cmp_field("quarter_pulse", SAMPLE_W'(want.quarter_pulse),
                              SAMPLE_W'(res_bus.quarter_pulse));
                    cmp_field("click_sample", want.click_sample, res_bus.click_sample);
                    cmp_field("click_active", SAMPLE_W'(want.click_active),
                              SAMPLE_W'(res_bus.click_active));
                end
            end
            if (item_bus.valid && item_bus.ready)
                midi_beats_due.push_back(next_midi_beat(item_bus.kind, item_bus.click_index,
                                                        item_bus.click_value));
            pending <= midi_beats_due.size();
        end
    end

endmodule

>>> tb/tb_midi_clock_metronome.sv
// Top of the MIDI clock metronome testbench: clock, reset, stimulus with
// random idling on both sides, watchdog and verdict.
// Depends on mcm_pkg, the channel interfaces, midi_clock_metronome, mcm_checker.
`timescale 1ns / 1ps

module tb_midi_clock_metronome
    import mcm_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_BEATS    = 40;
    // a click is cut by the length write at each phase start, so it never
    // reaches past the first PHASE_BEATS table entries
    localparam int CLICK_FILL     = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;
    localparam logic [CFG_DATA_W-1:0]  ONE_Q16      = CFG_DATA_W'(ONE_SAMPLE_Q16);
    localparam logic [CFG_DATA_W-1:0]  SPT_MAX      = '1;
    localparam logic [CFG_DATA_W-1:0]  LEN_MAX      = CFG_DATA_W'((1 << LEN_W) - 1);
    localparam logic [CFG_DATA_W-1:0]  CFG_ONE      = CFG_DATA_W'(1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic rx_ready = 1'b0;
    int   rx_mode = 0;
    int   mode_left = 0;
    int   stall_left = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    mcm_item_if   item_bus();
    mcm_result_if res_bus();
    mcm_cfg_if    cfg_bus();

    assign res_bus.ready = rx_ready;

    midi_clock_metronome dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    mcm_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_bus   (item_bus),
        .res_bus    (res_bus),
        .cfg_bus    (cfg_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stalls: always ready, coin flip, or mostly ready with long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready   <= 1'b0;
            mode_left  <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 80);
            end
            else
                mode_left <= mode_left - 1;
            if (stall_left != 0)
            begin
                rx_ready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                case (rx_mode)
                    0: rx_ready <= 1'b1;
                    1: rx_ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            rx_ready   <= 1'b0;
                            stall_left <= $urandom_range(4, 30);
                        end
                        else
                            rx_ready <= 1'b1;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d results due",
                     $time, idle_cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item_bus.valid       <= 1'b1;
        item_bus.kind        <= kind;
        item_bus.click_index <= idx;
        item_bus.click_value <= val;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random_beat();
        int               roll;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 74)
            kind = KIND_SAMPLE;
        else if (roll < 79)
            kind = KIND_START;
        else if (roll < 83)
            kind = KIND_STOP;
        else if (roll < 87)
            kind = KIND_CONTINUE;
        else if (roll < 96)
            kind = KIND_LOAD;
        else
            kind = KIND_W'($urandom_range(int'(KIND_LOAD) + 1, (1 << KIND_W) - 1));
        send_beat(kind, INDEX_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value, input bit last);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        if (last)
            cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] spt,
                              input logic [CFG_DATA_W-1:0] en,
                              input logic [CFG_DATA_W-1:0] len);
        program_reg(REG_SAMPLES_PER_TICK, spt, 1'b0);
        program_reg(REG_CLICK_ENABLE, en, 1'b0);
        program_reg(REG_CLICK_LENGTH, len, 1'b1);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] spt;
        logic [CFG_DATA_W-1:0] en;
        logic [CFG_DATA_W-1:0] len;
        item_bus.valid       <= 1'b0;
        item_bus.kind        <= KIND_SAMPLE;
        item_bus.click_index <= '0;
        item_bus.click_value <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= REG_SAMPLES_PER_TICK;
        cfg_bus.data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero period runs at one tick per sample
        program_reg(REG_UNMAPPED, SPT_MAX, 1'b0);
        set_config('0, CFG_ONE, CFG_DATA_W'(3));
        send_beat(KIND_LOAD, '0, 16'h7FFF);
        send_beat(KIND_LOAD, 8'd1, 16'h8000);
        send_beat(KIND_LOAD, 8'd2, 16'hFFFF);
        send_beat(KIND_LOAD, '1, 16'h0000);
        for (int k = int'(KIND_LOAD) + 1; k < (1 << KIND_W); k++)
            send_beat(KIND_W'(k), '1, '1);
        send_beat(KIND_SAMPLE, '0, '0);
        send_beat(KIND_CONTINUE, '0, '0);
        send_beat(KIND_STOP, '0, '0);
        send_beat(KIND_START, '0, '0);
        repeat (6) send_beat(KIND_SAMPLE, '0, '0);
        wait_drained();
        program_reg(REG_SAMPLES_PER_TICK, CFG_DATA_W'(10 * ONE_Q16), 1'b1);
        repeat (4) send_beat(KIND_SAMPLE, '0, '0);
        // period lowered below the phase: back-to-back clocks until caught up
        wait_drained();
        program_reg(REG_SAMPLES_PER_TICK, CFG_DATA_W'(2 * ONE_Q16), 1'b1);
        repeat (5) send_beat(KIND_SAMPLE, '0, '0);

        for (int i = 0; i < CLICK_FILL; i++)
            send_beat(KIND_LOAD, INDEX_W'(i), SAMPLE_W'($urandom));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: begin spt = ONE_Q16; en = CFG_ONE; len = CFG_DATA_W'(20); end
                1: begin spt = CFG_DATA_W'(ONE_Q16 + $urandom_range(0, 65535)); en = CFG_ONE;
                         len = CFG_DATA_W'($urandom_range(1, 64)); end
                2: begin spt = '0; en = CFG_ONE; len = CFG_DATA_W'(CLICK_DEPTH_DEFAULT); end
                3: begin spt = ONE_Q16; en = CFG_ONE; len = LEN_MAX; end
                4: begin spt = SPT_MAX; en = '0; len = CFG_DATA_W'($urandom_range(0, 256)); end
                5: begin spt = CFG_DATA_W'(ONE_Q16 * $urandom_range(1, 4));
                         en = CFG_DATA_W'($urandom_range(0, 1));
                         len = CFG_DATA_W'($urandom_range(0, 256)); end
                6: begin spt = ONE_Q16; en = CFG_ONE; len = '0; end
                default: begin spt = CFG_DATA_W'(ONE_Q16 + $urandom_range(0, 65536));
                               en = CFG_ONE;
                               len = CFG_DATA_W'($urandom_range(1, 256)); end
            endcase
            set_config(spt, en, len);
            send_beat(KIND_START, '0, '0);
            for (int n = 1; n < PHASE_BEATS; n++)
            begin
                if (phase == PHASES - 1 && n == PHASE_BEATS / 2)
                begin
                    // period change alone leaves a running click alone
                    wait_drained();
                    program_reg(REG_SAMPLES_PER_TICK, ONE_Q16, 1'b1);
                end
                send_random_beat();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
